// ----- hdl/tptt_pkg.sv -----
// tptt_pkg: shared sizes, item types and tlb cell types for the page table translator
// no dependencies; compile first

package tptt_pkg;

    localparam int TLB_DEPTH   = 16;
    localparam int PAGE_COUNT  = 256;
    localparam int OFFSET_BITS = 8;
    localparam int FRAME_COUNT = 256;

    localparam int ADDR_W  = 16;
    localparam int PAGE_W  = $clog2(PAGE_COUNT);
    localparam int FRAME_W = $clog2(FRAME_COUNT);
    localparam int COUNT_W = 16;
    localparam int FILL_W  = $clog2(TLB_DEPTH + 1);

    typedef struct packed {
        logic               valid;
        logic [PAGE_W-1:0]  tag;
        logic [FRAME_W-1:0] frame;
    } tlb_entry_t;

    typedef struct packed {
        logic load;
        logic shift;
    } tlb_ctl_t;

    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] frame;
    } tlb_look_t;

    typedef struct packed {
        logic [PAGE_W-1:0]  page_number;
        logic [FRAME_W-1:0] frame_number;
        logic [ADDR_W-1:0]  physical_address;
        logic               tlb_hit;
        logic               page_fault;
        logic [COUNT_W-1:0] hit_count;
        logic [COUNT_W-1:0] fault_count;
    } out_item_t;

endpackage

// ----- hdl/tptt_req_if.sv -----
// tptt_req_if, tptt_rsp_if: valid/ready channels for address and translation items
// depends on tptt_pkg

interface tptt_req_if import tptt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] logical_address;

    modport source (output valid, output logical_address, input ready);
    modport sink (input valid, input logical_address, output ready);
endinterface

interface tptt_rsp_if import tptt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PAGE_W-1:0]  page_number;
    logic [FRAME_W-1:0] frame_number;
    logic [ADDR_W-1:0]  physical_address;
    logic               tlb_hit;
    logic               page_fault;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] fault_count;

    modport source (output valid, output page_number, output frame_number,
                    output physical_address, output tlb_hit, output page_fault,
                    output hit_count, output fault_count, input ready);
    modport sink (input valid, input page_number, input frame_number,
                  input physical_address, input tlb_hit, input page_fault,
                  input hit_count, input fault_count, output ready);
endinterface

// ----- hdl/tptt_cell.sv -----
// tptt_cell: one tlb slot holding tag, frame and valid, with compare and priority pass-through
// depends on tptt_pkg

module tptt_cell import tptt_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  tlb_ctl_t           ctl,
    input  logic [PAGE_W-1:0]  ins_page,
    input  logic [FRAME_W-1:0] ins_frame,
    input  tlb_entry_t         next_entry,
    input  logic [PAGE_W-1:0]  look_page,
    input  tlb_look_t          chain_in,
    output tlb_entry_t         entry,
    output tlb_look_t          chain_out
);

    tlb_entry_t entry_reg;
    tlb_entry_t entry_next;
    logic       match;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.load)
        begin
            entry_next.valid = 1'b1;
            entry_next.tag   = ins_page;
            entry_next.frame = ins_frame;
        end
        else if (ctl.shift)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign match           = entry_reg.valid && (entry_reg.tag == look_page);
    assign chain_out.found = chain_in.found | match;
    assign chain_out.frame = chain_in.found ? chain_in.frame : entry_reg.frame;
    assign entry           = entry_reg;

endmodule

// ----- hdl/tptt_tlb.sv -----
// tptt_tlb: row of tlb cells with in-order fill and fifo shift once full
// depends on tptt_pkg and tptt_cell

module tptt_tlb import tptt_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [PAGE_W-1:0]  look_page,
    output tlb_look_t          look,
    input  logic               ins_en,
    input  logic [PAGE_W-1:0]  ins_page,
    input  logic [FRAME_W-1:0] ins_frame
);

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              full;
    tlb_look_t         chain [TLB_DEPTH+1];
    tlb_entry_t        entries [TLB_DEPTH];
    tlb_entry_t        nexts [TLB_DEPTH];
    tlb_ctl_t          ctls [TLB_DEPTH];

    assign full      = (fill_reg == FILL_W'(TLB_DEPTH));
    assign fill_next = (ins_en && !full) ? fill_reg + 1'b1 : fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    assign chain[0] = '0;

    for (genvar i = 0; i < TLB_DEPTH; i++)
    begin : g_cell
        if (i < TLB_DEPTH - 1)
        begin : g_mid
            assign nexts[i]      = entries[i+1];
            assign ctls[i].load  = ins_en && !full && (fill_reg == FILL_W'(i));
            assign ctls[i].shift = ins_en && full;
        end
        else
        begin : g_last
            assign nexts[i]      = '0;
            assign ctls[i].load  = ins_en && (full || (fill_reg == FILL_W'(i)));
            assign ctls[i].shift = 1'b0;
        end

        tptt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctls[i]),
            .ins_page   (ins_page),
            .ins_frame  (ins_frame),
            .next_entry (nexts[i]),
            .look_page  (look_page),
            .chain_in   (chain[i]),
            .entry      (entries[i]),
            .chain_out  (chain[i+1])
        );
    end

    assign look = chain[TLB_DEPTH];

endmodule

// ----- hdl/tlb_page_table_translator.sv -----
// tlb_page_table_translator: tlb cell row plus page table with demand frame allocation
// depends on tptt_pkg, tptt_req_if/tptt_rsp_if, tptt_tlb
//
//   channel  dir  carries
//   req      in   logical_address
//   rsp      out  page, frame, physical address, hit/fault flags, counts
//
// items pass one at a time through accept, tlb search with page table read, commit
// the page table read port's registered data sets the search state
// commit waits while the output register holds an item not yet taken
// a new item is accepted while the previous result waits in the output register
// reset clears tlb cells and page valid flops at once; no clearing pass

module tlb_page_table_translator import tptt_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    tptt_req_if.sink   req,
    tptt_rsp_if.source rsp
);

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_COMMIT} state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic               hit_reg;
    logic [FRAME_W-1:0] tlb_frame_reg;
    logic [FRAME_W-1:0] pt_rdata_reg;
    logic               pt_valid_reg;
    logic [FRAME_W-1:0] free_reg;
    logic [FRAME_W-1:0] free_next;
    logic [COUNT_W-1:0] hits_reg;
    logic [COUNT_W-1:0] hits_next;
    logic [COUNT_W-1:0] faults_reg;
    logic [COUNT_W-1:0] faults_next;
    out_item_t          out_reg;
    out_item_t          out_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [PAGE_COUNT-1:0] page_valid_reg;

    logic [FRAME_W-1:0] pt_mem [PAGE_COUNT];

    logic [PAGE_W-1:0]      page;
    logic [OFFSET_BITS-1:0] offset;
    tlb_look_t              look;
    logic                   out_free;
    logic                   commit;
    logic                   fault;
    logic [FRAME_W-1:0]     frame_sel;

    assign page      = PAGE_W'(addr_reg >> OFFSET_BITS);
    assign offset    = addr_reg[OFFSET_BITS-1:0];
    assign out_free  = !out_valid_reg || rsp.ready;
    assign commit    = (state_reg == S_COMMIT) && out_free;
    assign fault     = !hit_reg && !pt_valid_reg;
    assign frame_sel = hit_reg ? tlb_frame_reg : (pt_valid_reg ? pt_rdata_reg : free_reg);

    tptt_tlb u_tlb (
        .clk       (clk),
        .rst_n     (rst_n),
        .look_page (page),
        .look      (look),
        .ins_en    (commit && !hit_reg),
        .ins_page  (page),
        .ins_frame (frame_sel)
    );

    always_comb
    begin
        state_next     = state_reg;
        free_next      = free_reg;
        hits_next      = hits_reg;
        faults_next    = faults_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    if (hit_reg && (hits_reg != '1))
                    begin
                        hits_next = hits_reg + 1'b1;
                    end
                    if (fault)
                    begin
                        free_next = (free_reg == FRAME_W'(FRAME_COUNT - 1)) ?
                                    '0 : free_reg + 1'b1;
                        if (faults_reg != '1)
                        begin
                            faults_next = faults_reg + 1'b1;
                        end
                    end
                    out_next.page_number      = page;
                    out_next.frame_number     = frame_sel;
                    out_next.physical_address = ADDR_W'({frame_sel, offset});
                    out_next.tlb_hit          = hit_reg;
                    out_next.page_fault       = fault;
                    out_next.hit_count        = hits_next;
                    out_next.fault_count      = faults_next;
                    out_valid_next            = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_reg      <= '0;
            hits_reg      <= '0;
            faults_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            hits_reg      <= hits_next;
            faults_reg    <= faults_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (req.valid && req.ready)
        begin
            addr_reg <= req.logical_address;
        end
        if (state_reg == S_SEARCH)
        begin
            hit_reg       <= look.found;
            tlb_frame_reg <= look.frame;
            pt_valid_reg  <= page_valid_reg[page];
        end
    end

    // page table frames
    always_ff @(posedge clk)
    begin
        if (commit && fault)
        begin
            pt_mem[page] <= free_reg;
        end
        if (state_reg == S_SEARCH)
        begin
            pt_rdata_reg <= pt_mem[page];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_valid_reg <= '0;
        end
        else if (commit && fault)
        begin
            page_valid_reg[page] <= 1'b1;
        end
    end

    assign req.ready            = (state_reg == S_IDLE);
    assign rsp.valid            = out_valid_reg;
    assign rsp.page_number      = out_reg.page_number;
    assign rsp.frame_number     = out_reg.frame_number;
    assign rsp.physical_address = out_reg.physical_address;
    assign rsp.tlb_hit          = out_reg.tlb_hit;
    assign rsp.page_fault       = out_reg.page_fault;
    assign rsp.hit_count        = out_reg.hit_count;
    assign rsp.fault_count      = out_reg.fault_count;

endmodule

// ----- tb/tptt_translation_checker.sv -----
`timescale 1ns / 1ps
// tptt_translation_checker: watches the address and translation channels, predicts and checks each result
// depends on tptt_pkg and the tptt_req_if / tptt_rsp_if interfaces

module tptt_translation_checker import tptt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    tptt_req_if        req,
    tptt_rsp_if        rsp,
    output int         mismatches,
    output int         pending
);

    logic               page_known [PAGE_COUNT];
    logic [FRAME_W-1:0] page_frame [PAGE_COUNT];
    tlb_entry_t         tlb_row [TLB_DEPTH];
    logic [FILL_W-1:0]  tlb_fill;
    logic [FRAME_W-1:0] next_frame;
    logic [COUNT_W-1:0] hits_seen;
    logic [COUNT_W-1:0] faults_seen;

    out_item_t expected_translations [$];

    function automatic out_item_t translate_address(input logic [ADDR_W-1:0] addr);
        out_item_t              r;
        logic [PAGE_W-1:0]      page;
        logic [OFFSET_BITS-1:0] offset;
        logic [FRAME_W-1:0]     frame;
        logic                   hit;
        logic                   fault;
        page   = PAGE_W'((addr >> OFFSET_BITS) % PAGE_COUNT);
        offset = addr[OFFSET_BITS-1:0];
        frame  = '0;
        hit    = 1'b0;
        fault  = 1'b0;
        // lowest matching slot wins
        for (int i = 0; i < TLB_DEPTH; i++)
        begin
            if (!hit && tlb_row[i].valid && tlb_row[i].tag == page)
            begin
                hit   = 1'b1;
                frame = tlb_row[i].frame;
            end
        end
        if (hit)
        begin
            if (hits_seen != '1)
                hits_seen++;
        end
        else
        begin
            if (page_known[page])
                frame = page_frame[page];
            else
            begin
                fault            = 1'b1;
                frame            = next_frame;
                page_frame[page] = frame;
                page_known[page] = 1'b1;
                next_frame       = FRAME_W'((32'(next_frame) + 1) % FRAME_COUNT);
                if (faults_seen != '1)
                    faults_seen++;
            end
            // fifo fill, then shift out the oldest slot
            if (tlb_fill < TLB_DEPTH)
            begin
                tlb_row[tlb_fill] = '{valid: 1'b1, tag: page, frame: frame};
                tlb_fill++;
            end
            else
            begin
                for (int i = 0; i + 1 < TLB_DEPTH; i++)
                    tlb_row[i] = tlb_row[i+1];
                tlb_row[TLB_DEPTH-1] = '{valid: 1'b1, tag: page, frame: frame};
            end
        end
        r.page_number      = page;
        r.frame_number     = frame;
        r.physical_address = ADDR_W'((32'(frame) << OFFSET_BITS) | 32'(offset));
        r.tlb_hit          = hit;
        r.page_fault       = fault;
        r.hit_count        = hits_seen;
        r.fault_count      = faults_seen;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            expected_translations.delete();
            for (int i = 0; i < PAGE_COUNT; i++)
            begin
                page_known[i] = 1'b0;
                page_frame[i] = '0;
            end
            for (int i = 0; i < TLB_DEPTH; i++)
                tlb_row[i] = '0;
            tlb_fill    = '0;
            next_frame  = '0;
            hits_seen   = '0;
            faults_seen = '0;
            mismatches  = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_translations.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected result, expected nothing, actual page %0h",
                             $time, rsp.page_number);
                end
                else
                begin
                    want = expected_translations.pop_front();
                    check_field("page_number", want.page_number, rsp.page_number);
                    check_field("frame_number", want.frame_number, rsp.frame_number);
                    check_field("physical_address", want.physical_address,
                                rsp.physical_address);
                    check_field("tlb_hit", want.tlb_hit, rsp.tlb_hit);
                    check_field("page_fault", want.page_fault, rsp.page_fault);
                    check_field("hit_count", want.hit_count, rsp.hit_count);
                    check_field("fault_count", want.fault_count, rsp.fault_count);
                end
            end
            if (req.valid && req.ready)
                expected_translations.push_back(translate_address(req.logical_address));
        end
        pending = expected_translations.size();
    end

endmodule

// ----- tb/tlb_page_table_translator_tb.sv -----
`timescale 1ns / 1ps
// tlb_page_table_translator_tb: address stimulus, receiver stalls and verdict for the translator
// depends on tptt_pkg, the channel interfaces, the translator rtl and tptt_translation_checker

module tlb_page_table_translator_tb import tptt_pkg::*; ();

    localparam int CLK_PERIOD   = 8;
    localparam int RANDOM_ITEMS = 1470;
    localparam int STEADY_ITEMS = 100;
    localparam int RECENT_DEPTH = 24;

    localparam logic [ADDR_W-1:0] DIRECTED [24] = '{
        16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00, 16'h8000, 16'h7FFF, 16'hAA55, 16'h55AA,
        16'h0101, 16'h0202, 16'h0303, 16'h0404, 16'h0505, 16'h0606, 16'h0707, 16'h0808,
        16'h0909, 16'h0A0A, 16'h0B0B, 16'h0C0C, 16'h0012, 16'hFF34, 16'h8056, 16'h0C77
    };

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   pending;
    logic steady = 1'b0;
    int   burst_left = 0;

    tptt_req_if req ();
    tptt_rsp_if rsp ();

    tlb_page_table_translator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    tptt_translation_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic send_address(input logic [ADDR_W-1:0] addr);
        req.valid           <= 1'b1;
        req.logical_address <= addr;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
        if (!steady)
        begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                req.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 10);
            end
        end
    endtask

    task automatic wait_drain();
        req.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // receiver: runs of ready and stall of random length, always ready while steady is set
    initial
    begin
        int run_left;
        logic level;
        rsp.ready = 1'b0;
        run_left  = 0;
        level     = 1'b0;
        forever
        begin
            @(negedge clk);
            if (steady)
                rsp.ready <= 1'b1;
            else
            begin
                if (run_left == 0)
                begin
                    level = ~level;
                    if (level)
                        run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                               : $urandom_range(1, 20);
                    else
                        run_left = $urandom_range(1, 6);
                end
                run_left--;
                rsp.ready <= level;
            end
        end
    end

    initial
    begin
        logic [PAGE_W-1:0] hot_pages [4];
        logic [PAGE_W-1:0] recent_pages [RECENT_DEPTH];
        logic [PAGE_W-1:0] page;
        logic [OFFSET_BITS-1:0] offset;
        int pick;
        rst_n               = 1'b0;
        req.valid           = 1'b0;
        req.logical_address = '0;
        foreach (hot_pages[i])
            hot_pages[i] = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
        foreach (recent_pages[i])
            recent_pages[i] = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED[i])
            send_address(DIRECTED[i]);
        wait_drain();

        // locality-heavy mix: hot set, recently used pages, and uniform noise
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 99) == 0)
                wait_drain();
            if ($urandom_range(0, 49) == 0)
                hot_pages[$urandom_range(0, 3)] = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
            pick = $urandom_range(0, 99);
            if (pick < 40)
                page = hot_pages[$urandom_range(0, 3)];
            else if (pick < 70)
                page = recent_pages[$urandom_range(0, RECENT_DEPTH - 1)];
            else
                page = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
            case ($urandom_range(0, 9))
                0:       offset = '0;
                1:       offset = '1;
                default: offset = OFFSET_BITS'($urandom_range(0, (1 << OFFSET_BITS) - 1));
            endcase
            recent_pages[n % RECENT_DEPTH] = page;
            send_address({page, offset});
        end
        wait_drain();

        // touch every page so all frames get allocated and the allocator wraps
        for (int p = 0; p < PAGE_COUNT; p++)
            send_address({PAGE_W'(p), OFFSET_BITS'($urandom_range(0, (1 << OFFSET_BITS) - 1))});
        wait_drain();

        // repeated accesses to one page, which hit once it is in the tlb, with the receiver always ready
        steady = 1'b1;
        page   = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
        for (int n = 0; n < STEADY_ITEMS; n++)
            send_address({page, OFFSET_BITS'($urandom_range(0, (1 << OFFSET_BITS) - 1))});
        steady = 1'b0;
        wait_drain();

        repeat (10) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
